>>> src/sbp_pkg.sv
`timescale 1ns / 1ps

package sbp_pkg;

   localparam logic [7:0] HeaderByte   = 8'hFF;
   localparam logic [7:0] InsSyncWrite = 8'h83;
   localparam logic [7:0] InsBulkRead  = 8'h92;
   localparam logic [7:0] ChecksumGood = 8'hFF;
   localparam logic [7:0] NoPrevId     = 8'hFF;
   localparam logic [7:0] OwnIdReset   = 8'h01;

   typedef enum logic [6:0] {
      PH_HUNT1 = 7'b0000001,
      PH_HUNT2 = 7'b0000010,
      PH_ID    = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_INST  = 7'b0010000,
      PH_PARAM = 7'b0100000,
      PH_CHK   = 7'b1000000
   } phase_type;

   // One received byte as it leaves the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } word_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] packet_id;
      logic [7:0] instruction;
      logic       checksum_ok;
      logic       sync_present;
      logic [7:0] sync_address;
      logic [7:0] sync_length;
      logic       bulk_present;
      logic [7:0] bulk_address;
      logic [7:0] bulk_length;
      logic [7:0] bulk_prev_id;
   } rsp_type;

endpackage

>>> src/sbp_ifs.sv
`timescale 1ns / 1ps

interface sbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [7:0] packet_id;
   logic [7:0] instruction;
   logic       checksum_ok;
   logic       sync_present;
   logic [7:0] sync_address;
   logic [7:0] sync_length;
   logic       bulk_present;
   logic [7:0] bulk_address;
   logic [7:0] bulk_length;
   logic [7:0] bulk_prev_id;
   modport source (output valid, input ready, output kind, output data_byte,
                   output packet_id, output instruction, output checksum_ok,
                   output sync_present, output sync_address, output sync_length,
                   output bulk_present, output bulk_address, output bulk_length,
                   output bulk_prev_id);
   modport sink (input valid, output ready, input kind, input data_byte,
                 input packet_id, input instruction, input checksum_ok,
                 input sync_present, input sync_address, input sync_length,
                 input bulk_present, input bulk_address, input bulk_length,
                 input bulk_prev_id);
endinterface

interface sbp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] own_id;
   modport source (output valid, output own_id, input ready);
   modport sink (input valid, input own_id, output ready);
endinterface

>>> src/sbp_in_stage.sv
`timescale 1ns / 1ps

module sbp_in_stage (
   input  logic             clock,
   input  logic             reset,
   sbp_req_if.sink          req_ch,
   input  logic             advance,
   output sbp_pkg::word_type word
);
   import sbp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   // The register frees up in the same cycle that its word moves on.
   assign req_ch.ready = !reset && (!in_valid_ff || advance);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         byte_in     = req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word.valid   = in_valid_ff;
   assign word.rx_byte = byte_ff;

endmodule

>>> src/sbp_parser.sv
`timescale 1ns / 1ps

module sbp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        own_id,
   output logic              res_valid,
   output sbp_pkg::rsp_type  res
);
   import sbp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_id_ff, held_id_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] held_instruction_ff, held_instruction_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] entry_pos_ff, entry_pos_in;
   logic [7:0] prev_id_ff, prev_id_in;
   logic [7:0] sync_address_ff, sync_address_in;
   logic [7:0] sync_length_ff, sync_length_in;
   logic       sync_flag_ff, sync_flag_in;
   logic       bulk_flag_ff, bulk_flag_in;
   logic       busy_ff, busy_in;
   logic [7:0] bulk_length_ff, bulk_length_in;
   logic [7:0] bulk_address_ff, bulk_address_in;

   logic [7:0] total;
   logic [7:0] pos;
   logic [8:0] entry_span;
   logic [7:0] sum_next;

   assign total      = (held_length_ff >= 8'd2) ? (held_length_ff - 8'd2) : 8'd0;
   assign pos        = total - bytes_left_ff;
   assign entry_span = {1'b0, sync_length_ff} + 9'd1;
   assign sum_next   = running_sum_ff + rx_byte;

   always_comb begin
      phase_in            = phase_ff;
      held_id_in          = held_id_ff;
      held_length_in      = held_length_ff;
      held_instruction_in = held_instruction_ff;
      running_sum_in      = running_sum_ff;
      bytes_left_in       = bytes_left_ff;
      entry_pos_in        = entry_pos_ff;
      prev_id_in          = prev_id_ff;
      sync_address_in     = sync_address_ff;
      sync_length_in      = sync_length_ff;
      sync_flag_in        = sync_flag_ff;
      bulk_flag_in        = bulk_flag_ff;
      busy_in             = busy_ff;
      bulk_length_in      = bulk_length_ff;
      bulk_address_in     = bulk_address_ff;
      res_valid           = 1'b0;
      res                 = '0;

      if (fire) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == HeaderByte) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               phase_in = (rx_byte == HeaderByte) ? PH_ID : PH_HUNT1;
            end
            PH_ID: begin
               held_id_in      = rx_byte;
               running_sum_in  = rx_byte;
               sync_flag_in    = 1'b0;
               bulk_flag_in    = 1'b0;
               busy_in         = 1'b0;
               prev_id_in      = 8'd0;
               sync_address_in = 8'd0;
               sync_length_in  = 8'd0;
               bulk_length_in  = 8'd0;
               bulk_address_in = 8'd0;
               entry_pos_in    = 8'd0;
               phase_in        = PH_LEN;
            end
            PH_LEN: begin
               held_length_in = rx_byte;
               running_sum_in = sum_next;
               phase_in       = PH_INST;
            end
            PH_INST: begin
               held_instruction_in = rx_byte;
               running_sum_in      = sum_next;
               bytes_left_in       = total;
               phase_in            = (total != 8'd0) ? PH_PARAM : PH_CHK;
            end
            PH_PARAM: begin
               running_sum_in = sum_next;
               if (held_instruction_ff == InsSyncWrite) begin
                  if (pos == 8'd0) begin
                     sync_address_in = rx_byte;
                  end else if (pos == 8'd1) begin
                     sync_length_in = rx_byte;
                     entry_pos_in   = 8'd0;
                  end else if (entry_pos_ff == 8'd0) begin
                     // Id byte of an entry; only a complete entry may match.
                     if (!sync_flag_ff && ({1'b0, bytes_left_ff} >= entry_span)
                         && (rx_byte == own_id)) begin
                        sync_flag_in = 1'b1;
                        if (sync_length_ff != 8'd0) begin
                           busy_in = 1'b1;
                        end
                     end
                     entry_pos_in = (sync_length_ff == 8'd0) ? 8'd0 : 8'd1;
                  end else begin
                     if (busy_ff) begin
                        res_valid     = 1'b1;
                        res.kind      = 1'b0;
                        res.data_byte = rx_byte;
                     end
                     if (entry_pos_ff == sync_length_ff) begin
                        entry_pos_in = 8'd0;
                        busy_in      = 1'b0;
                     end else begin
                        entry_pos_in = entry_pos_ff + 8'd1;
                     end
                  end
               end else if (held_instruction_ff == InsBulkRead) begin
                  if (pos == 8'd0) begin
                     entry_pos_in = 8'd0;
                  end else begin
                     case (entry_pos_ff)
                        8'd0: begin
                           if (!bulk_flag_ff) begin
                              bulk_length_in = rx_byte;
                           end
                           entry_pos_in = 8'd1;
                        end
                        8'd1: begin
                           if (!bulk_flag_ff && (bytes_left_ff >= 8'd2)) begin
                              if (rx_byte == own_id) begin
                                 bulk_flag_in = 1'b1;
                                 busy_in      = 1'b1;
                              end else begin
                                 prev_id_in = rx_byte;
                              end
                           end
                           entry_pos_in = 8'd2;
                        end
                        default: begin
                           if (busy_ff) begin
                              bulk_address_in = rx_byte;
                              busy_in         = 1'b0;
                           end
                           entry_pos_in = 8'd0;
                        end
                     endcase
                  end
               end
               if (bytes_left_ff != 8'd0) begin
                  bytes_left_in = bytes_left_ff - 8'd1;
               end
               if (bytes_left_ff <= 8'd1) begin
                  phase_in = PH_CHK;
               end
            end
            PH_CHK: begin
               running_sum_in   = sum_next;
               res_valid        = 1'b1;
               res.kind         = 1'b1;
               res.packet_id    = held_id_ff;
               res.instruction  = held_instruction_ff;
               res.checksum_ok  = (sum_next == ChecksumGood);
               res.sync_present = sync_flag_ff;
               res.sync_address = sync_flag_ff ? sync_address_ff : 8'd0;
               res.sync_length  = sync_flag_ff ? sync_length_ff : 8'd0;
               res.bulk_present = bulk_flag_ff;
               res.bulk_address = bulk_flag_ff ? bulk_address_ff : 8'd0;
               res.bulk_length  = bulk_flag_ff ? bulk_length_ff : 8'd0;
               res.bulk_prev_id = bulk_flag_ff ? prev_id_ff : NoPrevId;
               phase_in         = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_HUNT1;
         held_id_ff          <= 8'd0;
         held_length_ff      <= 8'd0;
         held_instruction_ff <= 8'd0;
         running_sum_ff      <= 8'd0;
         bytes_left_ff       <= 8'd0;
         entry_pos_ff        <= 8'd0;
         prev_id_ff          <= 8'd0;
         sync_address_ff     <= 8'd0;
         sync_length_ff      <= 8'd0;
         sync_flag_ff        <= 1'b0;
         bulk_flag_ff        <= 1'b0;
         busy_ff             <= 1'b0;
         bulk_length_ff      <= 8'd0;
         bulk_address_ff     <= 8'd0;
      end else begin
         phase_ff            <= phase_in;
         held_id_ff          <= held_id_in;
         held_length_ff      <= held_length_in;
         held_instruction_ff <= held_instruction_in;
         running_sum_ff      <= running_sum_in;
         bytes_left_ff       <= bytes_left_in;
         entry_pos_ff        <= entry_pos_in;
         prev_id_ff          <= prev_id_in;
         sync_address_ff     <= sync_address_in;
         sync_length_ff      <= sync_length_in;
         sync_flag_ff        <= sync_flag_in;
         bulk_flag_ff        <= bulk_flag_in;
         busy_ff             <= busy_in;
         bulk_length_ff      <= bulk_length_in;
         bulk_address_ff     <= bulk_address_in;
      end
   end

endmodule

>>> src/sbp_out_stage.sv
`timescale 1ns / 1ps

module sbp_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             res_valid,
   input  sbp_pkg::rsp_type res,
   output logic             open,
   sbp_rsp_if.source        rsp_ch
);
   import sbp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // The register can take a new word when it is empty or being drained.
   assign open = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_ff.kind;
   assign rsp_ch.data_byte    = rsp_ff.data_byte;
   assign rsp_ch.packet_id    = rsp_ff.packet_id;
   assign rsp_ch.instruction  = rsp_ff.instruction;
   assign rsp_ch.checksum_ok  = rsp_ff.checksum_ok;
   assign rsp_ch.sync_present = rsp_ff.sync_present;
   assign rsp_ch.sync_address = rsp_ff.sync_address;
   assign rsp_ch.sync_length  = rsp_ff.sync_length;
   assign rsp_ch.bulk_present = rsp_ff.bulk_present;
   assign rsp_ch.bulk_address = rsp_ff.bulk_address;
   assign rsp_ch.bulk_length  = rsp_ff.bulk_length;
   assign rsp_ch.bulk_prev_id = rsp_ff.bulk_prev_id;

endmodule

>>> src/servo_bus_packet_parser.sv
// Receive-side packet parser for a half-duplex servo bus.
// req_ch carries one received bus byte per word. rsp_ch returns words of two
// kinds: kind 0 is a sync-write data byte addressed to this node, passed on
// as it arrives; kind 1 is the summary of a packet, sent after its checksum
// byte, with id, instruction, checksum status and the sync-write and
// bulk-read entries that matched this node.
// csr_ch writes own_id, the node's bus id. It is always ready outside reset
// and should only be written while no byte is in flight.
// A byte accepted into the input register is parsed when it moves on, and
// that parse loads the result register, from which the result is offered on
// rsp_ch. One byte is taken every cycle while rsp_ch does not stall; the
// parse step itself is combinational between the two registers.
// When rsp_ch stalls with a word held, the input register still takes one
// more byte, and req_ch.ready drops only once both registers are full.
// Reset returns the parser to hunting for the header, empties both
// registers and sets own_id to 1.
`timescale 1ns / 1ps

module servo_bus_packet_parser (
   input  logic      clock,
   input  logic      reset,
   sbp_req_if.sink   req_ch,
   sbp_rsp_if.source rsp_ch,
   sbp_csr_if.sink   csr_ch
);
   import sbp_pkg::*;

   word_type   word;
   logic       out_open;
   logic       fire;
   logic       res_valid;
   rsp_type    res;
   logic [7:0] own_id_ff, own_id_in;

   assign csr_ch.ready = !reset;
   assign own_id_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.own_id : own_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= OwnIdReset;
      end else begin
         own_id_ff <= own_id_in;
      end
   end

   assign fire = word.valid && out_open;

   sbp_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (fire),
      .word    (word)
   );

   sbp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (word.rx_byte),
      .own_id    (own_id_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   sbp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .open      (out_open),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> src/sbp_checker.sv
`timescale 1ns / 1ps

module sbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_packet_id
);

   // A held word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_packet_id))
      else $error("rsp payload changed while stalled");

   // A result that appears on an empty output comes from a byte that was taken
   // into the input register and then parsed into the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp word without a matching request byte");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind servo_bus_packet_parser sbp_checker u_sbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_kind      (rsp_ch.kind),
   .rsp_data_byte (rsp_ch.data_byte),
   .rsp_packet_id (rsp_ch.packet_id)
);
